FILE: rtl/vertex_tuple_dedup_indexer_unit_macros.svh
// Assertion macros shared by the vertex tuple dedup indexer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef VERTEX_TUPLE_DEDUP_INDEXER_UNIT_MACROS_SVH
`define VERTEX_TUPLE_DEDUP_INDEXER_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define VTDI_ASSERT(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define VTDI_ASSERT_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/vtdi_pkg.sv
// Shared constants and types for the vertex tuple dedup indexer.
// No dependencies; used by the RAM-facing top level.
package vtdi_pkg;

  localparam int TABLE_DEPTH      = 1024;
  localparam int ATTR_INDEX_WIDTH = 24;
  localparam int NUM_ATTRS        = 7;
  localparam int MASK_W           = 6;
  localparam int VERTEX_INDEX_W   = 10;
  localparam int UNIQUE_COUNT_W   = 11;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TUPLE_W = NUM_ATTRS * ATTR_INDEX_WIDTH;

  localparam logic [MASK_W-1:0] MASK_RESET = '1;

  typedef logic [NUM_ATTRS-1:0][ATTR_INDEX_WIDTH-1:0] tuple_t;

endpackage

FILE: rtl/vtdi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the unique tuple table.
module vtdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/vertex_tuple_dedup_indexer_unit.sv
// Top level of the vertex tuple dedup indexer: sequencer, comparator, output register.
// Depends on vtdi_pkg, vtdi_ram and vertex_tuple_dedup_indexer_unit_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one face corner a beat: start_mesh and
//   seven attribute indices. Output channel (out_valid/out_ready) returns one beat per
//   corner: vertex_index, is_new, overflow and unique_count. The cfg channel
//   (cfg_valid/cfg_ready/cfg_data) writes attribute_present_mask; write it only idle.
//   The block takes one corner at a time. A corner scans the stored tuples in order,
//   one table read per cycle through the single RAM read port and one shared tuple
//   comparator, and stops at the first hit. A miss compares every stored tuple, of
//   which there are at most 1024; with an empty table the scan is skipped.
//   in_ready rises again once the result is loaded into the output register.
//   Reset (rst, synchronous) empties the table, sets the mask to all ones and drops
//   out_valid; no clearing pass runs, the fill count alone marks valid entries.
//   If the receiver stalls, the result holds in the output register; the next corner
//   is still accepted and scanned, and waits for the output register before finishing.
`include "vertex_tuple_dedup_indexer_unit_macros.svh"

module vertex_tuple_dedup_indexer_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vtdi_pkg::MASK_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  start_mesh,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] position_index,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] texcoord_index,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] normal_index,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] tangent_index,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] binormal_index,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] color_index,
  input  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] blend_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [vtdi_pkg::VERTEX_INDEX_W-1:0]   vertex_index,
  output logic                                  is_new,
  output logic                                  overflow,
  output logic [vtdi_pkg::UNIQUE_COUNT_W-1:0]   unique_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                          state;
  logic [vtdi_pkg::MASK_W-1:0]     attr_mask;
  logic [vtdi_pkg::COUNT_W-1:0]    count;
  logic [vtdi_pkg::COUNT_W-1:0]    issue_ptr;
  logic                            cmp_valid;
  logic [vtdi_pkg::ADDR_W-1:0]     cmp_slot;
  logic                            res_hit;
  logic [vtdi_pkg::ADDR_W-1:0]     res_slot;
  vtdi_pkg::tuple_t                tuple;

  vtdi_pkg::tuple_t                in_tuple;
  logic [vtdi_pkg::COUNT_W-1:0]    count_next;
  logic                            in_fire;
  logic                            hit_now;
  logic                            last_cmp;
  logic                            issuing;
  logic                            full;
  logic                            out_free;
  logic                            append;
  logic [vtdi_pkg::TUPLE_W-1:0]    rd_data;

  // Absent optional attributes read as zero; position is always present.
  always_comb begin
    in_tuple[0] = position_index;
    in_tuple[1] = attr_mask[0] ? texcoord_index : '0;
    in_tuple[2] = attr_mask[1] ? normal_index   : '0;
    in_tuple[3] = attr_mask[2] ? tangent_index  : '0;
    in_tuple[4] = attr_mask[3] ? binormal_index : '0;
    in_tuple[5] = attr_mask[4] ? color_index    : '0;
    in_tuple[6] = attr_mask[5] ? blend_index    : '0;
  end

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign count_next = start_mesh ? '0 : count;

  assign hit_now  = cmp_valid && (rd_data == vtdi_pkg::TUPLE_W'(tuple));
  assign last_cmp = cmp_valid &&
                    (vtdi_pkg::COUNT_W'(cmp_slot) == count - vtdi_pkg::COUNT_W'(1));
  assign issuing  = (state == S_SCAN) && (issue_ptr < count) && !hit_now;
  assign full     = (count == vtdi_pkg::COUNT_W'(vtdi_pkg::TABLE_DEPTH));
  assign out_free = !out_valid || out_ready;
  assign append   = (state == S_RESULT) && out_free && !res_hit && !full;

  vtdi_ram #(
    .WIDTH (vtdi_pkg::TUPLE_W),
    .DEPTH (vtdi_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (append),
    .wr_addr (count[vtdi_pkg::ADDR_W-1:0]),
    .wr_data (vtdi_pkg::TUPLE_W'(tuple)),
    .rd_en   (issuing),
    .rd_addr (issue_ptr[vtdi_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      attr_mask <= vtdi_pkg::MASK_RESET;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_mask <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      cmp_valid <= issuing;
      cmp_slot  <= issue_ptr[vtdi_pkg::ADDR_W-1:0];

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            tuple     <= in_tuple;
            count     <= count_next;
            issue_ptr <= '0;
            res_hit   <= 1'b0;
            state     <= (count_next == '0) ? S_RESULT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_ptr <= issue_ptr + vtdi_pkg::COUNT_W'(1);
          end
          // Stop at the first hit; a miss is known once the last slot is compared.
          if (hit_now) begin
            res_hit  <= 1'b1;
            res_slot <= cmp_slot;
            state    <= S_RESULT;
          end else if (last_cmp) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (res_hit) begin
              vertex_index <= vtdi_pkg::VERTEX_INDEX_W'(res_slot);
              is_new       <= 1'b0;
              overflow     <= 1'b0;
              unique_count <= vtdi_pkg::UNIQUE_COUNT_W'(count);
            end else if (full) begin
              vertex_index <= '0;
              is_new       <= 1'b0;
              overflow     <= 1'b1;
              unique_count <= vtdi_pkg::UNIQUE_COUNT_W'(count);
            end else begin
              vertex_index <= vtdi_pkg::VERTEX_INDEX_W'(count);
              is_new       <= 1'b1;
              overflow     <= 1'b0;
              unique_count <= vtdi_pkg::UNIQUE_COUNT_W'(count + vtdi_pkg::COUNT_W'(1));
              count        <= count + vtdi_pkg::COUNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VTDI_ASSERT(a_busy_after_accept, clk, rst, in_fire |=> !in_ready, "ready after accept")
  `VTDI_ASSERT(a_count_bound, clk, rst,
    count <= vtdi_pkg::COUNT_W'(vtdi_pkg::TABLE_DEPTH), "count above table depth")
  `VTDI_ASSERT(a_read_stored_only, clk, rst, issuing |-> issue_ptr < count,
    "read beyond stored entries")
  `VTDI_ASSERT(a_new_index, clk, rst,
    out_valid && is_new |-> unique_count == vtdi_pkg::UNIQUE_COUNT_W'(vertex_index) + 1'b1,
    "appended index does not match count")
  `VTDI_ASSERT(a_overflow_full, clk, rst,
    out_valid && overflow |-> !is_new && vertex_index == '0, "overflow result malformed")
  `VTDI_ASSERT_ALWAYS(a_reset_idle, clk,
    rst |=> !out_valid && in_ready, "block not idle after reset")

endmodule

FILE: dv/vertex_tuple_dedup_indexer_unit_tb.sv
// Testbench for vertex_tuple_dedup_indexer_unit: directed, mask, stall and random traffic.
// Needs vtdi_pkg and the RTL top; every result is checked against a dedup table model.
module vertex_tuple_dedup_indexer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    ATTR_POSITION, ATTR_TEXCOORD, ATTR_NORMAL, ATTR_TANGENT,
    ATTR_BINORMAL, ATTR_COLOR, ATTR_BLEND
  } attr_slot_t;

  typedef struct {
    logic             start;
    vtdi_pkg::tuple_t attrs;
  } corner_t;

  typedef struct {
    logic [vtdi_pkg::VERTEX_INDEX_W-1:0] vertex_index;
    logic                                is_new;
    logic                                overflow;
    logic [vtdi_pkg::UNIQUE_COUNT_W-1:0] unique_count;
  } vertex_result_t;

  localparam logic [vtdi_pkg::MASK_W-1:0] MASK_NONE = '0;
  localparam logic [vtdi_pkg::MASK_W-1:0] MASK_ALL  = '1;
  localparam logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] ATTR_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vtdi_pkg::MASK_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_mesh = 1'b0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] position_index = '0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] texcoord_index = '0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] normal_index = '0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] tangent_index = '0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] binormal_index = '0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] color_index = '0;
  logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] blend_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [vtdi_pkg::VERTEX_INDEX_W-1:0] vertex_index;
  logic is_new;
  logic overflow;
  logic [vtdi_pkg::UNIQUE_COUNT_W-1:0] unique_count;

  // Dedup table model
  vtdi_pkg::tuple_t            stored_tuple [vtdi_pkg::TABLE_DEPTH];
  int                          table_fill = 0;
  logic [vtdi_pkg::MASK_W-1:0] present_mask = vtdi_pkg::MASK_RESET;

  vertex_result_t pending_vertices [$];
  int mismatch_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;

  vertex_tuple_dedup_indexer_unit uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_mesh     (start_mesh),
    .position_index (position_index),
    .texcoord_index (texcoord_index),
    .normal_index   (normal_index),
    .tangent_index  (tangent_index),
    .binormal_index (binormal_index),
    .color_index    (color_index),
    .blend_index    (blend_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .vertex_index   (vertex_index),
    .is_new         (is_new),
    .overflow       (overflow),
    .unique_count   (unique_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vertex_result_t dedup_lookup(corner_t c);
    vertex_result_t r;
    vtdi_pkg::tuple_t key;
    int hit;
    if (c.start) table_fill = 0;
    key = c.attrs;
    // clear the optional fields that are marked absent
    for (int a = ATTR_TEXCOORD; a < vtdi_pkg::NUM_ATTRS; a++)
      if (!present_mask[a-1]) key[a] = '0;
    hit = -1;
    for (int s = 0; s < table_fill && hit < 0; s++)
      if (stored_tuple[s] == key) hit = s;
    if (hit >= 0) begin
      r.vertex_index = vtdi_pkg::VERTEX_INDEX_W'(hit);
      r.is_new = 1'b0;
      r.overflow = 1'b0;
    end else if (table_fill >= vtdi_pkg::TABLE_DEPTH) begin
      r.vertex_index = '0;
      r.is_new = 1'b0;
      r.overflow = 1'b1;
    end else begin
      stored_tuple[table_fill] = key;
      r.vertex_index = vtdi_pkg::VERTEX_INDEX_W'(table_fill);
      r.is_new = 1'b1;
      r.overflow = 1'b0;
      table_fill++;
    end
    r.unique_count = vtdi_pkg::UNIQUE_COUNT_W'(table_fill);
    return r;
  endfunction

  function automatic corner_t corner_of(logic s, vtdi_pkg::tuple_t t);
    corner_t c;
    c.start = s;
    c.attrs = t;
    return c;
  endfunction

  function automatic logic [vtdi_pkg::ATTR_INDEX_WIDTH-1:0] random_attr();
    // favor small values so that random tuples collide now and then
    if ($urandom_range(2) == 0) return vtdi_pkg::ATTR_INDEX_WIDTH'($urandom());
    return vtdi_pkg::ATTR_INDEX_WIDTH'($urandom_range(3));
  endfunction

  function automatic vtdi_pkg::tuple_t random_tuple();
    vtdi_pkg::tuple_t t;
    for (int a = 0; a < vtdi_pkg::NUM_ATTRS; a++)
      t[a] = vtdi_pkg::ATTR_INDEX_WIDTH'($urandom());
    return t;
  endfunction

  function automatic corner_t random_corner();
    corner_t c;
    int mode;
    int slot;
    c.start = ($urandom_range(19) == 0) || (table_fill >= 40);
    mode = $urandom_range(99);
    if (table_fill > 0 && mode < 55) begin
      // revisit a stored tuple; absent fields may take any value and still hit
      slot = $urandom_range(table_fill - 1);
      c.attrs = stored_tuple[slot];
      for (int a = ATTR_TEXCOORD; a < vtdi_pkg::NUM_ATTRS; a++)
        if (!present_mask[a-1] && $urandom_range(1)) c.attrs[a] = random_attr();
      if (mode >= 35) c.attrs[$urandom_range(vtdi_pkg::NUM_ATTRS - 1)] = random_attr();
    end else begin
      for (int a = 0; a < vtdi_pkg::NUM_ATTRS; a++) c.attrs[a] = random_attr();
    end
    return c;
  endfunction

  task automatic send_corner(corner_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    start_mesh     <= c.start;
    position_index <= c.attrs[ATTR_POSITION];
    texcoord_index <= c.attrs[ATTR_TEXCOORD];
    normal_index   <= c.attrs[ATTR_NORMAL];
    tangent_index  <= c.attrs[ATTR_TANGENT];
    binormal_index <= c.attrs[ATTR_BINORMAL];
    color_index    <= c.attrs[ATTR_COLOR];
    blend_index    <= c.attrs[ATTR_BLEND];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_vertices.insert(pending_vertices.size(), dedup_lookup(c));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic write_attr_mask(logic [vtdi_pkg::MASK_W-1:0] m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    present_mask = m;
    @(posedge clk);
  endtask

  function automatic void note_mismatch(string field, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endfunction

  always @(posedge clk) begin : check_results
    vertex_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        note_mismatch("unexpected beat, vertex_index", -1, int'(vertex_index));
      end else begin
        want = pending_vertices.pop_front();
        if (vertex_index !== want.vertex_index)
          note_mismatch("vertex_index", int'(want.vertex_index), int'(vertex_index));
        if (is_new !== want.is_new)
          note_mismatch("is_new", int'(want.is_new), int'(is_new));
        if (overflow !== want.overflow)
          note_mismatch("overflow", int'(want.overflow), int'(overflow));
        if (unique_count !== want.unique_count)
          note_mismatch("unique_count", int'(want.unique_count), int'(unique_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic test_basic_dedup();
    vtdi_pkg::tuple_t t;
    send_corner(corner_of(1'b0, '0));
    send_corner(corner_of(1'b0, {vtdi_pkg::NUM_ATTRS{ATTR_ONES}}));
    send_corner(corner_of(1'b0, '0));
    send_corner(corner_of(1'b0, {vtdi_pkg::NUM_ATTRS{ATTR_ONES}}));
    // one field off zero at a time exercises each comparator lane
    for (int a = 0; a < vtdi_pkg::NUM_ATTRS; a++) begin
      t = '0;
      t[a] = (a % 2) ? 24'hAAAAAA : 24'h555555;
      send_corner(corner_of(1'b0, t));
    end
    t = '0;
    t[ATTR_TANGENT] = 24'hAAAAAA;
    send_corner(corner_of(1'b0, t));
    send_corner(corner_of(1'b1, {vtdi_pkg::NUM_ATTRS{ATTR_ONES}}));
    send_corner(corner_of(1'b1, {vtdi_pkg::NUM_ATTRS{ATTR_ONES}}));
    send_corner(corner_of(1'b0, '0));
  endtask

  task automatic test_attribute_mask();
    vtdi_pkg::tuple_t t;
    write_attr_mask(MASK_NONE);
    t = random_tuple();
    t[ATTR_POSITION] = vtdi_pkg::ATTR_INDEX_WIDTH'(5);
    send_corner(corner_of(1'b1, t));
    t = random_tuple();
    t[ATTR_POSITION] = vtdi_pkg::ATTR_INDEX_WIDTH'(5);
    send_corner(corner_of(1'b0, t));
    t[ATTR_POSITION] = vtdi_pkg::ATTR_INDEX_WIDTH'(6);
    send_corner(corner_of(1'b0, t));
    write_attr_mask(6'b101010);
    t = random_tuple();
    t[ATTR_POSITION] = vtdi_pkg::ATTR_INDEX_WIDTH'(5);
    send_corner(corner_of(1'b0, t));
    t[ATTR_TEXCOORD] = ~t[ATTR_TEXCOORD];
    t[ATTR_COLOR] = ~t[ATTR_COLOR];
    send_corner(corner_of(1'b0, t));
    write_attr_mask(6'b010101);
    t = random_tuple();
    t[ATTR_POSITION] = vtdi_pkg::ATTR_INDEX_WIDTH'(6);
    send_corner(corner_of(1'b0, t));
    t[ATTR_NORMAL] = ~t[ATTR_NORMAL];
    t[ATTR_BLEND] = ~t[ATTR_BLEND];
    send_corner(corner_of(1'b0, t));
    write_attr_mask(MASK_ALL);
    t = random_tuple();
    send_corner(corner_of(1'b0, t));
    send_corner(corner_of(1'b0, t));
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // stall the receiver long enough for the block to back up into its input
    rx_hold_left <= 300;
    send_corner(corner_of(1'b1, random_tuple()));
    for (int i = 0; i < 19; i++) send_corner(random_corner());
    drain_results();
  endtask

  task automatic test_random_traffic();
    int tx_pct [3] = '{29, 82, 0};
    int rx_pct [3] = '{82, 29, 0};
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      for (int b = 0; b < 3; b++) begin
        write_attr_mask(vtdi_pkg::MASK_W'($urandom_range(MASK_ALL)));
        for (int i = 0; i < 60; i++) send_corner(random_corner());
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 29;
    rx_idle_pct = 82;
    test_basic_dedup();
    test_attribute_mask();
    test_backpressure();
    test_random_traffic();
    drain_results();
    // allow one full scan for any stray beat
    repeat (1100) @(posedge clk);
    if (mismatch_count == 0 && pending_vertices.size() == 0) begin
      $display("vertex_tuple_dedup_indexer_unit test passed");
    end else begin
      $display("vertex_tuple_dedup_indexer_unit test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("vertex_tuple_dedup_indexer_unit test failed");
    $finish;
  end

endmodule

FILE: vertex_tuple_dedup_indexer_unit.f
+incdir+rtl
rtl/vtdi_pkg.sv
rtl/vtdi_ram.sv
rtl/vertex_tuple_dedup_indexer_unit.sv
dv/vertex_tuple_dedup_indexer_unit_tb.sv
